### hw/rtl/tcr_pkg.sv
// Shared constants, codes and types of the triangle coverage rasterizer.
`timescale 1ns / 1ps

package tcr_pkg;

    // Default parameter values
    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int SCREEN_BITS_DEF     = 12;

    // Fixed field widths
    localparam int COORD_W     = 16;          // raw vertex coordinate
    localparam int UNIT_W      = COORD_W + 1; // coordinate in half-LSB units
    localparam int DIFF_W      = UNIT_W + 1;  // difference of two coordinates
    localparam int SIZE_W      = 13;          // screen size registers
    localparam int PIX_W       = 12;          // pixel_x / pixel_y ports
    localparam int COLOR_W     = 24;
    localparam int STATUS_W    = 3;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    // Register indexes (paddr[2])
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Input operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PIXEL       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEGENERATE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OFF_SCREEN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_TRIANGLE = 3'd4;

    // Triangle geometry held for the pixel tests, after the winding swap
    typedef struct packed {
        logic signed [UNIT_W-1:0] x0;
        logic signed [UNIT_W-1:0] y0;
        logic signed [UNIT_W-1:0] x1;
        logic signed [UNIT_W-1:0] y1;
        logic signed [UNIT_W-1:0] x2;
        logic signed [UNIT_W-1:0] y2;
        logic [COLOR_W-1:0]       color;
    } geom_t;

    // Occupancy of the edge pipeline, seen by the front
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } pipe_stat_t;

endpackage

### hw/rtl/tcr_fifo.sv
// Small register queue between the front and the edge pipeline.
`timescale 1ns / 1ps

module tcr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/tcr_front.sv
// Front end: takes beats, sets up triangles and walks the bounding box.
`timescale 1ns / 1ps

module tcr_front import tcr_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int SCREEN_BITS     = SCREEN_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              op,
    input  logic signed [COORD_W-1:0]         vertex0_x,
    input  logic signed [COORD_W-1:0]         vertex0_y,
    input  logic signed [COORD_W-1:0]         vertex1_x,
    input  logic signed [COORD_W-1:0]         vertex1_y,
    input  logic signed [COORD_W-1:0]         vertex2_x,
    input  logic signed [COORD_W-1:0]         vertex2_y,
    input  logic [COLOR_W-1:0]                fill_color,
    input  logic [SIZE_W-1:0]                 image_width,
    input  logic [SIZE_W-1:0]                 image_height,
    input  logic                              q_full,
    input  logic                              q_empty,
    input  pipe_stat_t                        pipe_stat,
    output logic                              q_push,
    output logic [STATUS_W+2*SCREEN_BITS:0]   q_data,
    output geom_t                             geom
);

    localparam int SPAN_W = SCREEN_BITS + COORD_FRAC_BITS + 2;
    localparam int BW     = ((UNIT_W > SPAN_W) ? UNIT_W : SPAN_W) + 1;
    localparam int EW     = (SIZE_W > SCREEN_BITS + 1) ? SIZE_W : SCREEN_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int AREA_W = PROD_W + 1;
    localparam int SH     = COORD_FRAC_BITS + 1;
    localparam logic signed [BW-1:0] HALF_U     = BW'(2 ** COORD_FRAC_BITS);
    localparam logic signed [BW-1:0] ONE_M1     = BW'(2 ** SH - 1);
    localparam logic [EW-1:0]        SCREEN_MAX = EW'(2 ** SCREEN_BITS);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_DONE} front_state_t;

    front_state_t             state_reg, state_next;
    logic                     active_reg, active_next;
    logic [SCREEN_BITS-1:0]   cur_x_reg, cur_x_next;
    logic [SCREEN_BITS-1:0]   cur_y_reg, cur_y_next;
    logic [SCREEN_BITS-1:0]   box_min_x_reg, box_min_x_next;
    logic [SCREEN_BITS-1:0]   box_max_x_reg, box_max_x_next;
    logic [SCREEN_BITS-1:0]   box_min_y_reg, box_min_y_next;
    logic [SCREEN_BITS-1:0]   box_max_y_reg, box_max_y_next;
    geom_t                    geom_reg, geom_next;

    // load set-up payload
    logic signed [UNIT_W-1:0] ld_x_reg [3];
    logic signed [UNIT_W-1:0] ld_y_reg [3];
    logic [COLOR_W-1:0]       ld_color_reg;
    logic signed [DIFF_W-1:0] d10x_reg, d10y_reg, d20x_reg, d20y_reg;
    logic signed [PROD_W-1:0] p_a_reg, p_b_reg;
    logic signed [BW-1:0]     fxc_reg, lxc_reg, fyc_reg, lyc_reg;

    logic                     accept;
    logic                     fin;
    logic                     drained;
    logic                     done_go;
    logic                     swap;
    logic                     empty_clip;
    logic                     empty_pix;
    logic [STATUS_W-1:0]      ld_status;
    logic signed [UNIT_W-1:0] in_x [3];
    logic signed [UNIT_W-1:0] in_y [3];
    logic signed [UNIT_W-1:0] min_x, max_x, min_y, max_y;
    logic signed [BW-1:0]     fx_e, lx_e, fy_e, ly_e;
    logic signed [BW-1:0]     lim_x, lim_y;
    logic signed [BW-1:0]     fxc, lxc, fyc, lyc;
    logic signed [BW-1:0]     pfx, plx, pfy, ply;
    logic [EW-1:0]            eff_w, eff_h;
    logic signed [AREA_W-1:0] area;

    function automatic logic signed [UNIT_W-1:0] min3(
        input logic signed [UNIT_W-1:0] a,
        input logic signed [UNIT_W-1:0] b,
        input logic signed [UNIT_W-1:0] c
    );
        logic signed [UNIT_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [UNIT_W-1:0] max3(
        input logic signed [UNIT_W-1:0] a,
        input logic signed [UNIT_W-1:0] b,
        input logic signed [UNIT_W-1:0] c
    );
        logic signed [UNIT_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // handshake and raw coordinates in half-LSB units
    assign full    = (state_reg != F_IDLE) || q_full;
    assign accept  = push && !full;
    assign in_x[0] = {vertex0_x, 1'b0};
    assign in_y[0] = {vertex0_y, 1'b0};
    assign in_x[1] = {vertex1_x, 1'b0};
    assign in_y[1] = {vertex1_y, 1'b0};
    assign in_x[2] = {vertex2_x, 1'b0};
    assign in_y[2] = {vertex2_y, 1'b0};
    assign geom    = geom_reg;

    // bounding box clipped at pixel centres (multiply cycle)
    always_comb
    begin
        min_x = min3(ld_x_reg[0], ld_x_reg[1], ld_x_reg[2]);
        max_x = max3(ld_x_reg[0], ld_x_reg[1], ld_x_reg[2]);
        min_y = min3(ld_y_reg[0], ld_y_reg[1], ld_y_reg[2]);
        max_y = max3(ld_y_reg[0], ld_y_reg[1], ld_y_reg[2]);
        fx_e  = BW'(min_x);
        lx_e  = BW'(max_x);
        fy_e  = BW'(min_y);
        ly_e  = BW'(max_y);
        eff_w = (EW'(image_width) > SCREEN_MAX) ? SCREEN_MAX : EW'(image_width);
        eff_h = (EW'(image_height) > SCREEN_MAX) ? SCREEN_MAX : EW'(image_height);
        lim_x = $signed(BW'(eff_w) << SH) - HALF_U;
        lim_y = $signed(BW'(eff_h) << SH) - HALF_U;
        fxc   = (fx_e < HALF_U) ? HALF_U : fx_e;
        fyc   = (fy_e < HALF_U) ? HALF_U : fy_e;
        lxc   = (lx_e > lim_x) ? lim_x : lx_e;
        lyc   = (ly_e > lim_y) ? lim_y : ly_e;
    end

    // area sign, pixel rounding and load verdict (done state)
    always_comb
    begin
        area       = {p_a_reg[PROD_W-1], p_a_reg} - {p_b_reg[PROD_W-1], p_b_reg};
        swap       = area[AREA_W-1];
        empty_clip = (fxc_reg > lxc_reg) || (fyc_reg > lyc_reg);
        pfx        = (fxc_reg - HALF_U + ONE_M1) >>> SH;
        plx        = (lxc_reg - HALF_U) >>> SH;
        pfy        = (fyc_reg - HALF_U + ONE_M1) >>> SH;
        ply        = (lyc_reg - HALF_U) >>> SH;
        empty_pix  = (pfx > plx) || (pfy > ply);
        if (area == '0)
        begin
            ld_status = ST_DEGENERATE;
        end
        else if (empty_clip || empty_pix)
        begin
            ld_status = ST_OFF_SCREEN;
        end
        else
        begin
            ld_status = ST_ACCEPTED;
        end
    end

    // geometry may change only once no pixel beat is left to test
    assign drained = q_empty && !pipe_stat.s1_valid && !pipe_stat.s2_valid;
    assign done_go = (state_reg == F_DONE) && !q_full
                     && ((ld_status != ST_ACCEPTED) || drained);
    assign fin     = (cur_x_reg == box_max_x_reg) && (cur_y_reg == box_max_y_reg);

    // queue beat
    always_comb
    begin
        q_push = done_go || (accept && (op == OP_STEP));
        if (done_go)
        begin
            q_data = {ld_status, {(2 * SCREEN_BITS + 1){1'b0}}};
        end
        else if (active_reg)
        begin
            q_data = {ST_PIXEL, cur_x_reg, cur_y_reg, fin};
        end
        else
        begin
            q_data = {ST_NO_TRIANGLE, {(2 * SCREEN_BITS + 1){1'b0}}};
        end
    end

    // sequencer and triangle state
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        box_min_x_next = box_min_x_reg;
        box_max_x_next = box_max_x_reg;
        box_min_y_next = box_min_y_reg;
        box_max_y_next = box_max_y_reg;
        geom_next      = geom_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && (op == OP_LOAD))
                begin
                    state_next = F_MUL;
                end
                else if (accept && active_reg)
                begin
                    if (fin)
                    begin
                        active_next = 1'b0;
                    end
                    else if (cur_x_reg == box_max_x_reg)
                    begin
                        cur_x_next = box_min_x_reg;
                        cur_y_next = cur_y_reg + 1'b1;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + 1'b1;
                    end
                end
            end
            F_MUL:
            begin
                state_next = F_DONE;
            end
            F_DONE:
            begin
                if (done_go)
                begin
                    state_next  = F_IDLE;
                    active_next = (ld_status == ST_ACCEPTED);
                    if (ld_status == ST_ACCEPTED)
                    begin
                        box_min_x_next  = pfx[SCREEN_BITS-1:0];
                        box_max_x_next  = plx[SCREEN_BITS-1:0];
                        box_min_y_next  = pfy[SCREEN_BITS-1:0];
                        box_max_y_next  = ply[SCREEN_BITS-1:0];
                        cur_x_next      = pfx[SCREEN_BITS-1:0];
                        cur_y_next      = pfy[SCREEN_BITS-1:0];
                        geom_next.x0    = ld_x_reg[0];
                        geom_next.y0    = ld_y_reg[0];
                        geom_next.x1    = swap ? ld_x_reg[2] : ld_x_reg[1];
                        geom_next.y1    = swap ? ld_y_reg[2] : ld_y_reg[1];
                        geom_next.x2    = swap ? ld_x_reg[1] : ld_x_reg[2];
                        geom_next.y2    = swap ? ld_y_reg[1] : ld_y_reg[2];
                        geom_next.color = ld_color_reg;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            active_reg    <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            box_min_x_reg <= '0;
            box_max_x_reg <= '0;
            box_min_y_reg <= '0;
            box_max_y_reg <= '0;
            geom_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            box_min_x_reg <= box_min_x_next;
            box_max_x_reg <= box_max_x_next;
            box_min_y_reg <= box_min_y_next;
            box_max_y_reg <= box_max_y_next;
            geom_reg      <= geom_next;
        end
    end

    // load set-up datapath: capture, then area products and clipped box
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_LOAD))
        begin
            for (int i = 0; i < 3; i++)
            begin
                ld_x_reg[i] <= in_x[i];
                ld_y_reg[i] <= in_y[i];
            end
            ld_color_reg <= fill_color;
            d10x_reg     <= DIFF_W'(in_x[1]) - DIFF_W'(in_x[0]);
            d10y_reg     <= DIFF_W'(in_y[1]) - DIFF_W'(in_y[0]);
            d20x_reg     <= DIFF_W'(in_x[2]) - DIFF_W'(in_x[0]);
            d20y_reg     <= DIFF_W'(in_y[2]) - DIFF_W'(in_y[0]);
        end
        if (state_reg == F_MUL)
        begin
            p_a_reg <= d10x_reg * d20y_reg;
            p_b_reg <= d10y_reg * d20x_reg;
            fxc_reg <= fxc;
            lxc_reg <= lxc;
            fyc_reg <= fyc;
            lyc_reg <= lyc;
        end
    end

endmodule

### hw/rtl/tcr_back.sv
// Back end: edge function pipeline (differences, products) and result register.
`timescale 1ns / 1ps

module tcr_back import tcr_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int SCREEN_BITS     = SCREEN_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [STATUS_W+2*SCREEN_BITS:0] q_data,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  geom_t                           geom,
    output pipe_stat_t                      pipe_stat,
    output logic [STATUS_W-1:0]             status,
    output logic [PIX_W-1:0]                pixel_x,
    output logic [PIX_W-1:0]                pixel_y,
    output logic                            covered,
    output logic                            last,
    output logic [COLOR_W-1:0]              pixel_color,
    output logic                            empty,
    input  logic                            pop
);

    localparam int PW  = SCREEN_BITS + COORD_FRAC_BITS + 1;  // sample position
    localparam int QW  = ((UNIT_W > PW) ? UNIT_W : PW) + 2;  // sample minus vertex
    localparam int MW  = DIFF_W + QW;                        // one product
    localparam int EFW = MW + 1;                             // edge value
    localparam logic [PW-1:0] HALF_P = PW'(2 ** COORD_FRAC_BITS);

    logic                     s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic                     adv;

    logic [STATUS_W-1:0]      e_status;
    logic [SCREEN_BITS-1:0]   e_x, e_y;
    logic                     e_last;
    logic [PW-1:0]            px, py;
    logic signed [UNIT_W-1:0] ax [3];
    logic signed [UNIT_W-1:0] ay [3];
    logic signed [UNIT_W-1:0] bx [3];
    logic signed [UNIT_W-1:0] by [3];
    logic signed [DIFF_W-1:0] dx [3];
    logic signed [DIFF_W-1:0] dy [3];
    logic signed [QW-1:0]     qx [3];
    logic signed [QW-1:0]     qy [3];
    logic                     tl [3];

    // stage 1: differences
    logic [STATUS_W-1:0]      s1_status_reg;
    logic [SCREEN_BITS-1:0]   s1_x_reg, s1_y_reg;
    logic                     s1_last_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg [3];
    logic signed [DIFF_W-1:0] s1_dy_reg [3];
    logic signed [QW-1:0]     s1_qx_reg [3];
    logic signed [QW-1:0]     s1_qy_reg [3];
    logic                     s1_tl_reg [3];

    // stage 2: products
    logic [STATUS_W-1:0]      s2_status_reg;
    logic [SCREEN_BITS-1:0]   s2_x_reg, s2_y_reg;
    logic                     s2_last_reg;
    logic signed [MW-1:0]     s2_m1_reg [3];
    logic signed [MW-1:0]     s2_m2_reg [3];
    logic                     s2_tl_reg [3];

    // result register
    logic [STATUS_W-1:0]      status_reg;
    logic [PIX_W-1:0]         pixel_x_reg, pixel_y_reg;
    logic                     covered_reg, last_reg;
    logic [COLOR_W-1:0]       pixel_color_reg;

    logic signed [EFW-1:0]    edge_val [3];
    logic [2:0]               edge_ok;
    logic                     is_pix;

    // the whole pipe moves whenever the result register is free
    assign adv       = !out_valid_reg || pop;
    assign q_pop     = adv && !q_empty;
    assign empty     = !out_valid_reg;
    assign pipe_stat = '{s1_valid: s1_valid_reg, s2_valid: s2_valid_reg};

    // unpack the queue beat and form the pixel centre
    assign e_status = q_data[STATUS_W+2*SCREEN_BITS -: STATUS_W];
    assign e_x      = q_data[2*SCREEN_BITS -: SCREEN_BITS];
    assign e_y      = q_data[SCREEN_BITS -: SCREEN_BITS];
    assign e_last   = q_data[0];
    assign px       = (PW'(e_x) << (COORD_FRAC_BITS + 1)) | HALF_P;
    assign py       = (PW'(e_y) << (COORD_FRAC_BITS + 1)) | HALF_P;

    // edges v0->v1, v1->v2, v2->v0
    assign ax[0] = geom.x0;
    assign ay[0] = geom.y0;
    assign bx[0] = geom.x1;
    assign by[0] = geom.y1;
    assign ax[1] = geom.x1;
    assign ay[1] = geom.y1;
    assign bx[1] = geom.x2;
    assign by[1] = geom.y2;
    assign ax[2] = geom.x2;
    assign ay[2] = geom.y2;
    assign bx[2] = geom.x0;
    assign by[2] = geom.y0;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dx[k] = DIFF_W'(bx[k]) - DIFF_W'(ax[k]);
            dy[k] = DIFF_W'(by[k]) - DIFF_W'(ay[k]);
            qx[k] = QW'($signed({1'b0, px})) - QW'(ax[k]);
            qy[k] = QW'($signed({1'b0, py})) - QW'(ay[k]);
            // top edge (horizontal, going right) or left edge (going up)
            tl[k] = (dy[k] < 0) || ((dy[k] == '0) && (dx[k] > 0));
        end
    end

    // edge values and the fill rule
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            edge_val[k] = EFW'(s2_m1_reg[k]) - EFW'(s2_m2_reg[k]);
            edge_ok[k]  = (edge_val[k] > 0) || ((edge_val[k] == '0) && s2_tl_reg[k]);
        end
        is_pix = (s2_status_reg == ST_PIXEL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_status_reg <= e_status;
            s1_x_reg      <= e_x;
            s1_y_reg      <= e_y;
            s1_last_reg   <= e_last;
            s2_status_reg <= s1_status_reg;
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_last_reg   <= s1_last_reg;
            for (int k = 0; k < 3; k++)
            begin
                s1_dx_reg[k] <= dx[k];
                s1_dy_reg[k] <= dy[k];
                s1_qx_reg[k] <= qx[k];
                s1_qy_reg[k] <= qy[k];
                s1_tl_reg[k] <= tl[k];
                s2_m1_reg[k] <= s1_dx_reg[k] * s1_qy_reg[k];
                s2_m2_reg[k] <= s1_dy_reg[k] * s1_qx_reg[k];
                s2_tl_reg[k] <= s1_tl_reg[k];
            end
            status_reg      <= s2_status_reg;
            pixel_x_reg     <= is_pix ? PIX_W'(s2_x_reg) : '0;
            pixel_y_reg     <= is_pix ? PIX_W'(s2_y_reg) : '0;
            covered_reg     <= is_pix && (&edge_ok);
            last_reg        <= is_pix && s2_last_reg;
            pixel_color_reg <= is_pix ? geom.color : '0;
        end
    end

    assign status      = status_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign covered     = covered_reg;
    assign last        = last_reg;
    assign pixel_color = pixel_color_reg;

endmodule

### hw/rtl/triangle_coverage_rasterizer.sv
// Triangle coverage rasterizer: configuration registers, front, queue and edge pipeline.
// Step beats: one per clock unless full; queue, then stage 1, stage 2, result register.
// Load beats: full stays high during set-up (area products, then the verdict);
// an accepted triangle also waits until no earlier pixel beat is left in the edge pipeline.
// Edge pipeline: six multipliers, one pixel centre per cycle unless a result is held.
// Reset (rst_n low, asynchronous): no triangle, empty queue, width 640, height 480.
`timescale 1ns / 1ps

module triangle_coverage_rasterizer import tcr_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int SCREEN_BITS     = SCREEN_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // item input
    input  logic                      push,
    output logic                      full,
    input  logic                      op,
    input  logic signed [COORD_W-1:0] vertex0_x,
    input  logic signed [COORD_W-1:0] vertex0_y,
    input  logic signed [COORD_W-1:0] vertex1_x,
    input  logic signed [COORD_W-1:0] vertex1_y,
    input  logic signed [COORD_W-1:0] vertex2_x,
    input  logic signed [COORD_W-1:0] vertex2_y,
    input  logic [COLOR_W-1:0]        fill_color,
    // results
    output logic                      empty,
    input  logic                      pop,
    output logic [STATUS_W-1:0]       status,
    output logic [PIX_W-1:0]          pixel_x,
    output logic [PIX_W-1:0]          pixel_y,
    output logic                      covered,
    output logic                      last,
    output logic [COLOR_W-1:0]        pixel_color,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0]     pwdata,
    output logic [CFG_DATA_W-1:0]     prdata,
    output logic                      pready
);

    localparam int ENTRY_W = STATUS_W + 2 * SCREEN_BITS + 1;

    logic [SIZE_W-1:0]  image_width_reg;
    logic [SIZE_W-1:0]  image_height_reg;
    logic               cfg_wr;
    logic               q_push, q_pop, q_full, q_empty;
    logic [ENTRY_W-1:0] q_wr_data, q_rd_data;
    pipe_stat_t         pipe_stat;
    geom_t              geom;
    logic               drained;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[SIZE_W-1:0];
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    tcr_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .SCREEN_BITS     (SCREEN_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .vertex0_x    (vertex0_x),
        .vertex0_y    (vertex0_y),
        .vertex1_x    (vertex1_x),
        .vertex1_y    (vertex1_y),
        .vertex2_x    (vertex2_x),
        .vertex2_y    (vertex2_y),
        .fill_color   (fill_color),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_full       (q_full),
        .q_empty      (q_empty),
        .pipe_stat    (pipe_stat),
        .q_push       (q_push),
        .q_data       (q_wr_data),
        .geom         (geom)
    );

    tcr_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty),
        .full    (q_full)
    );

    tcr_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .SCREEN_BITS     (SCREEN_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_rd_data),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .geom        (geom),
        .pipe_stat   (pipe_stat),
        .status      (status),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .covered     (covered),
        .last        (last),
        .pixel_color (pixel_color),
        .empty       (empty),
        .pop         (pop)
    );

    // checks
    assign drained = q_empty && !pipe_stat.s1_valid && !pipe_stat.s2_valid;

    // a load beat keeps the front busy for its set-up
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && (op == OP_LOAD)) |=> full)
        else $error("front took a beat during triangle set-up");

    // the front never writes into a full queue
    a_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("queue written while full");

    // geometry changes only when no pixel beat still needs the old triangle
    a_geom_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(geom) |-> $past(drained))
        else $error("geometry replaced under pending pixel beats");

endmodule

### sim/tb.sv
// Self-checking testbench of the triangle coverage rasterizer: directed, limit and random beats.
`timescale 1ns / 1ps

module tb;
    import tcr_pkg::*;

    // Fixed-point geometry of the default build
    localparam longint UNIT_ONE    = longint'(1) << (COORD_FRAC_BITS_DEF + 1);
    localparam longint UNIT_HALF   = longint'(1) << COORD_FRAC_BITS_DEF;
    localparam int     SCR_MAX     = 1 << SCREEN_BITS_DEF;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     STALL_CYCLES  = 200;

    typedef struct packed {
        logic                    op;
        logic [2:0][COORD_W-1:0] vx;
        logic [2:0][COORD_W-1:0] vy;
        logic [COLOR_W-1:0]      color;
    } tri_beat_t;

    localparam int BEAT_W = $bits(tri_beat_t);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PIX_W-1:0]    px;
        logic [PIX_W-1:0]    py;
        logic                covered;
        logic                last;
        logic [COLOR_W-1:0]  color;
    } pix_res_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic                      op;
    logic signed [COORD_W-1:0] vertex0_x, vertex0_y, vertex1_x, vertex1_y;
    logic signed [COORD_W-1:0] vertex2_x, vertex2_y;
    logic [COLOR_W-1:0]        fill_color;
    logic                      empty;
    logic                      pop;
    logic [STATUS_W-1:0]       status;
    logic [PIX_W-1:0]          pixel_x, pixel_y;
    logic                      covered, last;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0]     paddr;
    logic [CFG_DATA_W-1:0]     pwdata;
    logic [CFG_DATA_W-1:0]     prdata;
    logic                      pready;

    // Predicted block state
    int                scr_w = 640;
    int                scr_h = 480;
    longint            tri_x[3];
    longint            tri_y[3];
    logic [PIX_W-1:0]  box_x0, box_x1, box_y0, box_y1;
    logic [PIX_W-1:0]  cur_x, cur_y;
    bit                tri_live;
    logic [COLOR_W-1:0] tri_color;

    pix_res_t raster_out_q[$];

    // Run control and tallies
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_request = 0;
    int fail_count = 0;
    int n_loads = 0;
    int n_steps = 0;
    int n_results = 0;
    int n_covered = 0;
    int n_screens = 0;
    int cycle_count = 0;

    triangle_coverage_rasterizer DUT (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .op(op),
        .vertex0_x(vertex0_x), .vertex0_y(vertex0_y),
        .vertex1_x(vertex1_x), .vertex1_y(vertex1_y),
        .vertex2_x(vertex2_x), .vertex2_y(vertex2_y),
        .fill_color(fill_color),
        .empty(empty), .pop(pop), .status(status),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .covered(covered), .last(last),
        .pixel_color(pixel_color),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint edge_fn(input longint ax, ay, bx, by, px, py);
        return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    // Inside test with the top-left rule for samples exactly on the edge
    function automatic bit edge_in(input longint ax, ay, bx, by, px, py);
        longint e;
        e = edge_fn(ax, ay, bx, by, px, py);
        if (e != 0)
            return e > 0;
        return (by - ay) < 0 || ((by - ay) == 0 && (bx - ax) > 0);
    endfunction

    function automatic pix_res_t rasterise(input tri_beat_t b);
        pix_res_t r;
        longint   x[3];
        longint   y[3];
        longint   area, fx, lx, fy, ly, lim_x, lim_y, t, px, py;
        bit       fin;
        int       i;
        r = '0;
        if (b.op == OP_LOAD)
        begin
            tri_live = 1'b0;
            for (i = 0; i < 3; i++)
            begin
                x[i] = longint'($signed(b.vx[i])) * 2;
                y[i] = longint'($signed(b.vy[i])) * 2;
            end
            area = edge_fn(x[0], y[0], x[1], y[1], x[2], y[2]);
            if (area == 0)
                r.status = ST_DEGENERATE;
            else
            begin
                // clockwise triangles are rewound
                if (area < 0)
                begin
                    t = x[1]; x[1] = x[2]; x[2] = t;
                    t = y[1]; y[1] = y[2]; y[2] = t;
                end
                fx = x[0]; lx = x[0]; fy = y[0]; ly = y[0];
                for (i = 1; i < 3; i++)
                begin
                    if (x[i] < fx) fx = x[i];
                    if (x[i] > lx) lx = x[i];
                    if (y[i] < fy) fy = y[i];
                    if (y[i] > ly) ly = y[i];
                end
                lim_x = longint'((scr_w > SCR_MAX) ? SCR_MAX : scr_w) * UNIT_ONE - UNIT_HALF;
                lim_y = longint'((scr_h > SCR_MAX) ? SCR_MAX : scr_h) * UNIT_ONE - UNIT_HALF;
                if (fx < UNIT_HALF) fx = UNIT_HALF;
                if (fy < UNIT_HALF) fy = UNIT_HALF;
                if (lx > lim_x) lx = lim_x;
                if (ly > lim_y) ly = lim_y;
                if (fx > lx || fy > ly)
                    r.status = ST_OFF_SCREEN;
                else
                begin
                    // snap to the pixel centres inside the clipped extent
                    fx = (fx - UNIT_HALF + UNIT_ONE - 1) / UNIT_ONE;
                    lx = (lx - UNIT_HALF) / UNIT_ONE;
                    fy = (fy - UNIT_HALF + UNIT_ONE - 1) / UNIT_ONE;
                    ly = (ly - UNIT_HALF) / UNIT_ONE;
                    if (fx > lx || fy > ly)
                        r.status = ST_OFF_SCREEN;
                    else
                    begin
                        for (i = 0; i < 3; i++)
                        begin
                            tri_x[i] = x[i];
                            tri_y[i] = y[i];
                        end
                        box_x0 = fx[PIX_W-1:0];
                        box_x1 = lx[PIX_W-1:0];
                        box_y0 = fy[PIX_W-1:0];
                        box_y1 = ly[PIX_W-1:0];
                        cur_x = box_x0;
                        cur_y = box_y0;
                        tri_color = b.color;
                        tri_live = 1'b1;
                        r.status = ST_ACCEPTED;
                    end
                end
            end
        end
        else if (!tri_live)
            r.status = ST_NO_TRIANGLE;
        else
        begin
            px = longint'(cur_x) * UNIT_ONE + UNIT_HALF;
            py = longint'(cur_y) * UNIT_ONE + UNIT_HALF;
            fin = (cur_x == box_x1) && (cur_y == box_y1);
            r.status = ST_PIXEL;
            r.px = cur_x;
            r.py = cur_y;
            r.covered = edge_in(tri_x[0], tri_y[0], tri_x[1], tri_y[1], px, py)
                     && edge_in(tri_x[1], tri_y[1], tri_x[2], tri_y[2], px, py)
                     && edge_in(tri_x[2], tri_y[2], tri_x[0], tri_y[0], px, py);
            r.last = fin;
            r.color = tri_color;
            // raster order: along the row, then down
            if (fin)
                tri_live = 1'b0;
            else if (cur_x == box_x1)
            begin
                cur_x = box_x0;
                cur_y = cur_y + 1'b1;
            end
            else
                cur_x = cur_x + 1'b1;
        end
        return r;
    endfunction

    function automatic int box_pixels();
        if (!tri_live)
            return 0;
        return (int'(box_x1) - int'(box_x0) + 1) * (int'(box_y1) - int'(box_y0) + 1);
    endfunction

    // ---------------------------------------------------------------- beat builders

    function automatic tri_beat_t make_step();
        tri_beat_t b;
        b = BEAT_W'({$urandom, $urandom, $urandom, $urandom});
        b.op = OP_STEP;
        return b;
    endfunction

    function automatic tri_beat_t make_load(input int x0, y0, x1, y1, x2, y2,
                                            input logic [COLOR_W-1:0] colour);
        tri_beat_t b;
        b.op = OP_LOAD;
        b.vx[0] = x0[COORD_W-1:0]; b.vy[0] = y0[COORD_W-1:0];
        b.vx[1] = x1[COORD_W-1:0]; b.vy[1] = y1[COORD_W-1:0];
        b.vx[2] = x2[COORD_W-1:0]; b.vy[2] = y2[COORD_W-1:0];
        b.color = colour;
        return b;
    endfunction

    function automatic tri_beat_t noise_load();
        tri_beat_t b;
        b = BEAT_W'({$urandom, $urandom, $urandom, $urandom});
        b.op = OP_LOAD;
        return b;
    endfunction

    // Vertex near a pixel, often snapped onto a pixel centre to hit edge ties
    function automatic logic [COORD_W-1:0] jitter(input int c, input int span);
        int v;
        v = c * 16 + $urandom_range(2 * span * 16) - span * 16;
        if ($urandom_range(2) == 0)
            v = (v & ~15) | 8;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[COORD_W-1:0];
    endfunction

    function automatic tri_beat_t small_triangle();
        tri_beat_t b;
        int        w, h, cx, cy, span, i;
        w = (scr_w > SCR_MAX) ? SCR_MAX : scr_w;
        h = (scr_h > SCR_MAX) ? SCR_MAX : scr_h;
        if (w > 2040) w = 2040;
        if (h > 2040) h = 2040;
        if (w < 1) w = 1;
        if (h < 1) h = 1;
        // hug the screen borders often so clipping gets exercised
        case ($urandom_range(3))
            0: cx = 0;
            1: cx = w - 1;
            default: cx = $urandom_range(w - 1);
        endcase
        case ($urandom_range(3))
            0: cy = 0;
            1: cy = h - 1;
            default: cy = $urandom_range(h - 1);
        endcase
        span = $urandom_range(1, 6);
        b.op = OP_LOAD;
        for (i = 0; i < 3; i++)
        begin
            b.vx[i] = jitter(cx, span);
            b.vy[i] = jitter(cy, span);
        end
        if ($urandom_range(15) == 0)
        begin
            b.vx[2] = b.vx[0];
            b.vy[2] = b.vy[0];
        end
        b.color = COLOR_W'($urandom);
        return b;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic flag_fail(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // Offer one beat, wait for the handshake, then predict its result
    task automatic send_item(input tri_beat_t b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        op         <= b.op;
        vertex0_x  <= b.vx[0];
        vertex0_y  <= b.vy[0];
        vertex1_x  <= b.vx[1];
        vertex1_y  <= b.vy[1];
        vertex2_x  <= b.vx[2];
        vertex2_y  <= b.vy[2];
        fill_color <= b.color;
        @(posedge clk);
        while (full)
            @(posedge clk);
        raster_out_q.push_back(rasterise(b));
        if (b.op == OP_LOAD)
            n_loads++;
        else
            n_steps++;
    endtask

    task automatic send_steps(input int count);
        repeat (count)
            send_item(make_step());
    endtask

    // Stop offering beats and wait until every result is back
    task automatic settle();
        push <= 1'b0;
        while (raster_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic apb_check(input logic idx);
        int want;
        want = (idx == REG_IMAGE_WIDTH) ? scr_w : scr_h;
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[SIZE_W-1:0] !== want[SIZE_W-1:0])
            flag_fail($sformatf("tb: register %0d reads %0d, expected %0d",
                                idx, prdata[SIZE_W-1:0], want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write a screen size with junk in the unused upper bits, then read it back
    task automatic apb_write(input logic idx, input int value);
        logic [CFG_DATA_W-1:0] word;
        word = $urandom;
        word[SIZE_W-1:0] = value[SIZE_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            scr_w = value & 32'h1FFF;
        else
            scr_h = value & 32'h1FFF;
        @(posedge clk);
        apb_check(idx);
    endtask

    task automatic set_screen(input int w, input int h);
        apb_write(REG_IMAGE_WIDTH, w);
        apb_write(REG_IMAGE_HEIGHT, h);
        n_screens++;
    endtask

    // ---------------------------------------------------------------- result checker

    initial
    begin
        pix_res_t got;
        pix_res_t want;
        int       stall_left;
        stall_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got.status  = status;
                got.px      = pixel_x;
                got.py      = pixel_y;
                got.covered = covered;
                got.last    = last;
                got.color   = pixel_color;
                n_results++;
                if (got.status == ST_PIXEL && got.covered)
                    n_covered++;
                if (raster_out_q.size() == 0)
                    flag_fail($sformatf("tb: result beat with nothing pending: status %0d",
                                        got.status));
                else
                begin
                    want = raster_out_q.pop_front();
                    if (got !== want)
                        flag_fail($sformatf({"tb: mismatch on result %0d: expected ",
                            "st %0d x %0d y %0d cov %0b last %0b rgb %06h, got ",
                            "st %0d x %0d y %0d cov %0b last %0b rgb %06h"},
                            n_results, want.status, want.px, want.py, want.covered,
                            want.last, want.color, got.status, got.px, got.py,
                            got.covered, got.last, got.color));
                end
            end
            // long hold-off when asked, otherwise random idling
            if (stall_request > 0)
            begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_register_reset();
        apb_check(REG_IMAGE_WIDTH);
        apb_check(REG_IMAGE_HEIGHT);
    endtask

    task automatic test_directed_cases();
        // step with nothing loaded
        send_item(make_step());
        // full-range vertices, every coordinate bit at both values
        send_item(make_load(-32768, -32768, 32767, -32768, -32768, 32767, 24'hFFFFFF));
        send_steps(2);
        // zero area drops the triangle in traversal; the next step finds none
        send_item(make_load(-32768, 32767, -32768, 32767, -32768, 32767, 24'h000000));
        send_item(make_step());
        // entirely left of and above the screen
        send_item(make_load(-400, -400, -100, -400, -400, -100, 24'h123456));
        // entirely right of a 640 wide screen
        send_item(make_load(32767, 0, 32000, 0, 32767, 100, 24'h654321));
        // extent inside one pixel, between centres
        send_item(make_load(26, 26, 30, 26, 26, 30, 24'hABCDEF));
        // vertices on pixel centres: edges pass exactly through samples
        send_item(make_load(8, 8, 40, 8, 8, 40, 24'h0F0F0F));
        send_steps(9);
        // clockwise winding gets swapped; one step past the end
        send_item(make_load(0, 0, 0, 32, 32, 0, 24'hF0F0F0));
        send_steps(5);
        settle();
    endtask

    task automatic test_screen_limits();
        int ws[6] = '{0, 640, 1, 8191, 4096, 4097};
        int hs[6] = '{480, 0, 1, 4097, 4096, 1};
        int k;
        for (k = 0; k < 6; k++)
        begin
            set_screen(ws[k], hs[k]);
            send_item(small_triangle());
            send_steps((box_pixels() > 6) ? 6 : box_pixels());
            send_item(make_load(-32768, -32768, 32767, -32768, -32768, 32767,
                                COLOR_W'($urandom)));
            send_steps(3);
            settle();
        end
    endtask

    // Hold the receiver off while steps keep coming, so the input stalls
    task automatic test_input_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_screen(640, 480);
        send_item(make_load(-32768, -32768, 32767, -32768, -32768, 32767,
                            COLOR_W'($urandom)));
        stall_request = STALL_CYCLES;
        send_steps(60);
        settle();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input int w, input int h, input int count);
        int sent;
        int npix;
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        set_screen(w, h);
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                // well-formed: load, walk the box, sometimes cut short or overrun
                send_item(small_triangle());
                npix = box_pixels();
                if ($urandom_range(7) == 0)
                    npix = $urandom_range(npix);
                else
                    npix += $urandom_range(2);
                send_steps(npix);
                sent += npix + 1;
            end
            else if (pick < 92)
            begin
                npix = $urandom_range(4);
                send_item(noise_load());
                send_steps(npix);
                sent += npix + 1;
            end
            else
            begin
                npix = $urandom_range(1, 3);
                send_steps(npix);
                sent += npix;
            end
        end
        settle();
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n      <= 1'b0;
        push       <= 1'b0;
        op         <= OP_LOAD;
        vertex0_x  <= '0;
        vertex0_y  <= '0;
        vertex1_x  <= '0;
        vertex1_y  <= '0;
        vertex2_x  <= '0;
        vertex2_y  <= '0;
        fill_color <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_cases();
        test_screen_limits();
        test_input_stall();
        test_random_traffic(28, 55, 97, 33, 600);
        test_random_traffic(55, 28, 4096, 2, 600);
        test_random_traffic(0, 0, $urandom_range(1, 8191), $urandom_range(1, 8191), 600);

        settle();
        if (raster_out_q.size() != 0)
            flag_fail($sformatf("tb: %0d results never arrived", raster_out_q.size()));
        $display("tb: %0d loads and %0d pixel steps over %0d screen sizes, %0d cycles",
                 n_loads, n_steps, n_screens, cycle_count);
        $display("tb: %0d result beats checked, %0d covered pixels, %0d faults",
                 n_results, n_covered, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tcr_pkg.sv
hw/rtl/tcr_fifo.sv
hw/rtl/tcr_front.sv
hw/rtl/tcr_back.sv
hw/rtl/triangle_coverage_rasterizer.sv
sim/tb.sv
